[sv/bbaa_pkg.sv]
// ----------------------------------------------------------------------------
// bbaa_pkg
// Shared types, codes and constants of the batch admission arbiter.
// ----------------------------------------------------------------------------
package bbaa_pkg;

    // Defaults and fixed limits
    localparam int unsigned MAX_COUNT_DEFAULT = 255;
    localparam logic [7:0]  BATCH_DEFAULT     = 8'd5;
    localparam logic [7:0]  BATCH_CAP         = 8'd255;

    // Configuration port
    localparam int unsigned APB_AW             = 2;
    localparam int unsigned APB_DW             = 32;
    localparam logic [APB_AW-1:0] ADDR_BATCH_LIM = '0;

    // Request codes
    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_DEPART = 1'b1;

    // Travel / previous direction codes
    localparam logic TRAVEL_UP = 1'b0;
    localparam logic TRAVEL_DN = 1'b1;

    // Crossing direction
    typedef enum logic [1:0] {
        CROSS_IDLE = 2'd0,
        CROSS_UP   = 2'd1,
        CROSS_DN   = 2'd2
    } t_dir;

    // One result beat
    typedef struct packed {
        logic [7:0] granted_count;
        logic       granted_dir;
        logic [1:0] current_dir;
        logic [7:0] occupancy;
        logic       overflow;
    } t_result;

    // Direction choice when the resource is empty
    function automatic t_dir pick_dir(input logic up_waits, input logic down_waits,
                                      input logic prev);
        t_dir d;
        if (up_waits && !down_waits) begin
            d = CROSS_UP;
        end else if (down_waits && !up_waits) begin
            d = CROSS_DN;
        end else if (!up_waits && !down_waits) begin
            d = CROSS_IDLE;
        end else begin
            d = (prev == TRAVEL_UP) ? CROSS_DN : CROSS_UP;
        end
        return d;
    endfunction

endpackage

[sv/bidirectional_batch_admission_arbiter_top.sv]
// ----------------------------------------------------------------------------
// bidirectional_batch_admission_arbiter_top
// Direction arbiter with a batch limit for a shared one-way resource.
// ----------------------------------------------------------------------------
// Every input beat is an arrival (req_type 0, with its travel direction) or a
// departure (req_type 1), and it yields exactly one result beat: how many
// waiters were admitted and in which direction, the crossing direction and
// occupancy after the event, and an overflow flag when an arrival is dropped
// because its waiting counter sits at MAX_COUNT. The block takes one beat per
// clock cycle while the output side does not stall; a beat lands in the input
// register when accepted, is evaluated against the arbiter state as it moves
// into the result register (grant count is a closed-form minimum, so the whole
// update is one pass of logic), and its result is offered from there. The
// result register lets the input side keep flowing while a result waits;
// the input stalls only when both registers are full and the output side
// stalls. The batch limit (APB word 0, reset 5; 0 acts as 5) sets how many
// users enter in one direction before yielding to a waiting opposite side;
// write it only while the block is idle. MAX_COUNT sizes the waiting and
// occupancy counters; the reported counts are the low 8 bits.
// ----------------------------------------------------------------------------
module bidirectional_batch_admission_arbiter_top #(
    parameter int unsigned MAX_COUNT = bbaa_pkg::MAX_COUNT_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic                         i_travel_dir,
    // Result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_granted_count,
    output logic                         o_granted_dir,
    output logic [1:0]                   o_current_dir,
    output logic [7:0]                   o_occupancy,
    output logic                         o_overflow,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bbaa_pkg::APB_AW-1:0]  paddr,
    input  logic [bbaa_pkg::APB_DW-1:0]  pwdata,
    output logic [bbaa_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import bbaa_pkg::*;

    logic       r_in_valid;
    logic       r_req_type;
    logic       r_travel_dir;
    logic       r_out_valid;
    t_result    r_res;
    t_result    core_res;
    logic [7:0] batch_lim;
    logic       adv;
    logic       in_take;

    // Advance the held beat when the result register is free or draining
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: capture on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req_type   <= i_req_type;
            r_travel_dir <= i_travel_dir;
        end
        if (adv) begin
            r_res <= core_res;
        end
    end

    bbaa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_batch_lim (batch_lim)
    );

    bbaa_core #(
        .MAX_COUNT (MAX_COUNT)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_req_type   (r_req_type),
        .i_travel_dir (r_travel_dir),
        .i_batch_lim  (batch_lim),
        .o_result     (core_res)
    );

    assign o_out_valid     = r_out_valid;
    assign o_granted_count = r_res.granted_count;
    assign o_granted_dir   = r_res.granted_dir;
    assign o_current_dir   = r_res.current_dir;
    assign o_occupancy     = r_res.occupancy;
    assign o_overflow      = r_res.overflow;

endmodule

[sv/bbaa_cfg.sv]
// ----------------------------------------------------------------------------
// bbaa_cfg
// Register block: holds the batch limit, written and read over the APB-style port.
// ----------------------------------------------------------------------------
module bbaa_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bbaa_pkg::APB_AW-1:0]  paddr,
    input  logic [bbaa_pkg::APB_DW-1:0]  pwdata,
    output logic [bbaa_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output logic [7:0]                   o_batch_lim
);
    import bbaa_pkg::*;

    logic [7:0] r_batch_lim;
    logic       wr_en;

    assign pready = 1'b1;
    // Only one register: a write to any address writes it; only address zero reads it
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_lim <= BATCH_DEFAULT;
        end else if (wr_en) begin
            r_batch_lim <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_BATCH_LIM) begin
            prdata = {{(APB_DW-8){1'b0}}, r_batch_lim};
        end
    end

    assign o_batch_lim = r_batch_lim;

endmodule

[sv/bbaa_core.sv]
// ----------------------------------------------------------------------------
// bbaa_core
// Arbiter state and the single-pass update for one arrival or departure.
// ----------------------------------------------------------------------------
module bbaa_core #(
    parameter int unsigned MAX_COUNT = bbaa_pkg::MAX_COUNT_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_req_type,
    input  logic              i_travel_dir,
    input  logic [7:0]        i_batch_lim,
    output bbaa_pkg::t_result o_result
);
    import bbaa_pkg::*;

    localparam int unsigned CW = $clog2(MAX_COUNT + 1);
    localparam int unsigned MW = (CW > 8) ? CW : 8;
    localparam int unsigned SW = MW + 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_COUNT);

    // State
    t_dir          r_cross, n_cross;
    logic [CW-1:0] r_users, n_users;
    logic [CW-1:0] r_wait_up, n_wait_up;
    logic [CW-1:0] r_wait_down, n_wait_down;
    logic [7:0]    r_batch, n_batch;
    logic          r_blocked, n_blocked;
    logic          r_prev, n_prev;

    // Pre-admission view
    t_dir          cross1;
    logic [CW-1:0] users1, wu1, wd1;
    logic [7:0]    ba1;
    logic          blk1, prev1;
    logic          ovf, do_admit;
    logic [MW-1:0] limit;

    // Admission
    logic [7:0]    mb, room_b, ba2;
    logic [MW-1:0] own_w, room_occ, n_adm;
    logic          opp_nz;
    logic [SW-1:0] ba_sum;

    always_comb begin
        wu1      = r_wait_up;
        wd1      = r_wait_down;
        users1   = r_users;
        cross1   = r_cross;
        ba1      = r_batch;
        blk1     = r_blocked;
        prev1    = r_prev;
        ovf      = 1'b0;
        do_admit = 1'b0;
        limit    = '0;

        if (i_req_type == REQ_ARRIVE) begin
            if (((i_travel_dir == TRAVEL_DN) ? r_wait_down : r_wait_up) >= MAXC) begin
                // Drop the arrival
                ovf = 1'b1;
            end else begin
                if (i_travel_dir == TRAVEL_DN) begin
                    wd1 = r_wait_down + CW'(1);
                end else begin
                    wu1 = r_wait_up + CW'(1);
                end
                if (r_users == '0) begin
                    cross1 = pick_dir(wu1 != '0, wd1 != '0, r_prev);
                    if (cross1 != CROSS_IDLE) begin
                        ba1  = '0;
                        blk1 = 1'b0;
                    end
                end
                do_admit = (cross1 == ((i_travel_dir == TRAVEL_DN) ? CROSS_DN : CROSS_UP));
                limit    = MW'(1);
            end
        end else begin
            if (r_users != '0) begin
                users1 = r_users - CW'(1);
            end
            if (users1 == '0) begin
                prev1  = (r_cross == CROSS_UP) ? TRAVEL_UP : TRAVEL_DN;
                cross1 = pick_dir(r_wait_up != '0, r_wait_down != '0, prev1);
                ba1    = '0;
                blk1   = 1'b0;
            end
            do_admit = 1'b1;
            limit    = MW'(MAX_COUNT);
        end

        // Closed-form grant: min of waiters, limit, free room and batch room
        mb       = (i_batch_lim == '0) ? BATCH_DEFAULT : i_batch_lim;
        own_w    = (cross1 == CROSS_UP) ? MW'(wu1) : MW'(wd1);
        opp_nz   = (cross1 == CROSS_UP) ? (wd1 != '0) : (wu1 != '0);
        room_occ = MW'(MAXC - users1);
        room_b   = (ba1 < mb) ? (mb - ba1) : 8'd1;
        n_adm    = (own_w < limit) ? own_w : limit;
        if (room_occ < n_adm) begin
            n_adm = room_occ;
        end
        if (opp_nz && (MW'(room_b) < n_adm)) begin
            n_adm = MW'(room_b);
        end
        if (!do_admit || (cross1 == CROSS_IDLE) || blk1) begin
            n_adm = '0;
        end

        ba_sum = SW'(ba1) + SW'(n_adm);
        ba2    = (ba_sum > SW'(BATCH_CAP)) ? BATCH_CAP : ba_sum[7:0];

        n_cross     = cross1;
        n_users     = users1;
        n_wait_up   = wu1;
        n_wait_down = wd1;
        n_batch     = ba1;
        n_blocked   = blk1;
        n_prev      = prev1;
        if (n_adm != '0) begin
            n_users = users1 + CW'(n_adm);
            if (cross1 == CROSS_UP) begin
                n_wait_up = wu1 - CW'(n_adm);
            end else begin
                n_wait_down = wd1 - CW'(n_adm);
            end
            n_batch = ba2;
            if (opp_nz && (ba2 >= mb)) begin
                n_blocked = 1'b1;
            end
        end

        o_result.granted_count = 8'(n_adm);
        o_result.granted_dir   = (n_adm != '0) && (cross1 == CROSS_DN);
        o_result.current_dir   = n_cross;
        o_result.occupancy     = 8'(n_users);
        o_result.overflow      = ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cross     <= CROSS_IDLE;
            r_users     <= '0;
            r_wait_up   <= '0;
            r_wait_down <= '0;
            r_batch     <= '0;
            r_blocked   <= 1'b0;
            r_prev      <= TRAVEL_DN;
        end else if (i_adv) begin
            r_cross     <= n_cross;
            r_users     <= n_users;
            r_wait_up   <= n_wait_up;
            r_wait_down <= n_wait_down;
            r_batch     <= n_batch;
            r_blocked   <= n_blocked;
            r_prev      <= n_prev;
        end
    end

endmodule

[bench/tb_bidirectional_batch_admission_arbiter_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bidirectional_batch_admission_arbiter_top
// Self-checking bench for the batch admission arbiter.
// ----------------------------------------------------------------------------
// Drive arrivals and departures into the arbiter and run an in-bench model of
// the admission rules in step with each accepted beat. Check every result
// beat field by field against the oldest predicted grant.
// The sequence of tests is as follows:
//   - Read back the reset batch limit.
//   - Run a short directed walk through the admission rules.
//   - Fill the waiting counters to overflow and the occupancy to its limit.
//   - Run random traffic over several batch limits.
//   - Finish with a stretch at full rate that has no gaps and no stalls.
// ----------------------------------------------------------------------------
module tb_bidirectional_batch_admission_arbiter_top;

    import bbaa_pkg::*;

    localparam int unsigned USER_LIMIT = MAX_COUNT_DEFAULT;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              in_valid     = 1'b0;
    logic              req_type     = REQ_ARRIVE;
    logic              travel_dir   = TRAVEL_UP;
    logic              out_stall    = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [APB_AW-1:0] paddr        = '0;
    logic [APB_DW-1:0] pwdata       = '0;

    logic              in_stall;
    logic              out_valid;
    logic [7:0]        granted_count;
    logic              granted_dir;
    logic [1:0]        current_dir;
    logic [7:0]        occupancy;
    logic              overflow;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Random idling on each side; clear both for a full-rate stretch
    bit gaps_on  = 1'b1;
    bit stall_on = 1'b1;

    int unsigned fail_count = 0;
    int unsigned beat_no    = 0;

    // Grants predicted for accepted beats, oldest first
    t_result grant_queue[$];
    t_result grant_seen;

    // ------------------------------------------------------------------
    // Arbiter model state
    // ------------------------------------------------------------------
    logic [7:0]  batch_limit;
    t_dir        cur_dir;
    int unsigned occ_now;
    int unsigned up_waiting;
    int unsigned down_waiting;
    int unsigned batch_count;
    bit          batch_held;
    logic        last_dir;

    bidirectional_batch_admission_arbiter_top #(
        .MAX_COUNT(USER_LIMIT)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_req_type      (req_type),
        .i_travel_dir    (travel_dir),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_granted_count (granted_count),
        .o_granted_dir   (granted_dir),
        .o_current_dir   (current_dir),
        .o_occupancy     (occupancy),
        .o_overflow      (overflow),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #200000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Error reporting: print one line and count
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        fail_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            flag_error($sformatf("beat %0d: %s is %0d, expected %0d",
                                 beat_no, name, got, want));
        end
    endtask

    // ------------------------------------------------------------------
    // Arbiter model
    // ------------------------------------------------------------------
    function automatic void reset_model();
        batch_limit  = BATCH_DEFAULT;
        cur_dir      = CROSS_IDLE;
        occ_now      = 0;
        up_waiting   = 0;
        down_waiting = 0;
        batch_count  = 0;
        batch_held   = 1'b0;
        last_dir     = TRAVEL_DN;
    endfunction

    // Direction taken when the resource is empty: the only side waiting,
    // or alternate away from the last direction when both wait
    function automatic t_dir choose_dir();
        if (up_waiting > 0 && down_waiting == 0) return CROSS_UP;
        if (down_waiting > 0 && up_waiting == 0) return CROSS_DN;
        if (up_waiting == 0 && down_waiting == 0) return CROSS_IDLE;
        return (last_dir == TRAVEL_UP) ? CROSS_DN : CROSS_UP;
    endfunction

    // Admit up to limit waiters of the crossing direction; bounded by the
    // occupancy ceiling and, while the other side waits, by the batch room
    function automatic int unsigned admit_waiters(input int unsigned limit);
        int unsigned own;
        int unsigned opp;
        int unsigned mb;
        int unsigned n;
        int unsigned room;
        if (cur_dir == CROSS_UP) begin
            own = up_waiting;
            opp = down_waiting;
        end else if (cur_dir == CROSS_DN) begin
            own = down_waiting;
            opp = up_waiting;
        end else begin
            return 0;
        end
        if (batch_held) return 0;
        mb   = (batch_limit == 8'd0) ? BATCH_DEFAULT : batch_limit;
        n    = (own < limit) ? own : limit;
        room = (occ_now < USER_LIMIT) ? USER_LIMIT - occ_now : 0;
        if (room < n) n = room;
        if (opp > 0) begin
            // once the batch is used up, one more still slips through
            room = (batch_count < mb) ? mb - batch_count : 1;
            if (room < n) n = room;
        end
        if (n == 0) return 0;
        occ_now += n;
        if (cur_dir == CROSS_UP) up_waiting -= n;
        else down_waiting -= n;
        batch_count = (batch_count + n > BATCH_CAP) ? BATCH_CAP : batch_count + n;
        if (opp > 0 && batch_count >= mb) batch_held = 1'b1;
        return n;
    endfunction

    // Advance the model by one input beat and return the expected result
    function automatic t_result arbitrate(input logic req, input logic dir);
        int unsigned granted;
        t_dir        pick;
        t_result     r;
        granted = 0;
        r       = '0;
        if (req == REQ_ARRIVE) begin
            if (((dir == TRAVEL_UP) ? up_waiting : down_waiting) >= USER_LIMIT) begin
                // drop the arrival, nothing else moves
                r.overflow = 1'b1;
            end else begin
                if (dir == TRAVEL_UP) up_waiting++;
                else down_waiting++;
                if (occ_now == 0) begin
                    pick    = choose_dir();
                    cur_dir = pick;
                    if (pick != CROSS_IDLE) begin
                        batch_count = 0;
                        batch_held  = 1'b0;
                    end
                end
                // only the newcomer may enter; other waiters stay put
                if ((dir == TRAVEL_UP && cur_dir == CROSS_UP) ||
                    (dir == TRAVEL_DN && cur_dir == CROSS_DN)) begin
                    granted = admit_waiters(1);
                end
            end
        end else begin
            if (occ_now > 0) occ_now--;
            if (occ_now == 0) begin
                // a direction of none counts as down here
                last_dir    = (cur_dir == CROSS_UP) ? TRAVEL_UP : TRAVEL_DN;
                cur_dir     = choose_dir();
                batch_count = 0;
                batch_held  = 1'b0;
            end
            granted = admit_waiters(USER_LIMIT);
        end
        r.granted_count = granted[7:0];
        r.granted_dir   = (granted > 0 && cur_dir == CROSS_DN) ? TRAVEL_DN : TRAVEL_UP;
        r.current_dir   = cur_dir;
        r.occupancy     = occ_now[7:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall at random, check every accepted beat
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        out_stall <= stall_on && ($urandom_range(99) < 8);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            beat_no++;
            if (grant_queue.size() == 0) begin
                flag_error($sformatf("beat %0d: result with no grant pending", beat_no));
            end else begin
                grant_seen = grant_queue.pop_front();
                check_field("granted_count", granted_count, grant_seen.granted_count);
                check_field("granted_dir", granted_dir, grant_seen.granted_dir);
                check_field("current_dir", current_dir, grant_seen.current_dir);
                check_field("occupancy", occupancy, grant_seen.occupancy);
                check_field("overflow", overflow, grant_seen.overflow);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Send one beat: idle at random first, hold the payload until accepted,
    // then advance the model. Valid stays high for a back-to-back beat.
    task automatic send_beat(input logic req, input logic dir);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        travel_dir <= dir;
        do @(posedge i_clk); while (in_stall);
        grant_queue.push_back(arbitrate(req, dir));
    endtask

    // Drop valid, wait for every pending grant, then let the pipe settle
    task automatic wait_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (grant_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Send departures until nobody is on the resource or waiting
    task automatic drain_resource();
        while (occ_now != 0 || up_waiting != 0 || down_waiting != 0) begin
            send_beat(REQ_DEPART, 1'($urandom_range(1)));
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write the batch limit while idle, mirror it in the model, read it back
    task automatic set_batch_limit(input logic [7:0] value);
        logic [APB_DW-1:0] rd;
        wait_idle();
        apb_access(1'b1, ADDR_BATCH_LIM, APB_DW'(value), rd);
        batch_limit = value;
        apb_access(1'b0, ADDR_BATCH_LIM, '0, rd);
        if (rd[7:0] != value) begin
            flag_error($sformatf("batch limit reads %0d, expected %0d", rd[7:0], value));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_values();
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, ADDR_BATCH_LIM, '0, rd);
        if (rd[7:0] != BATCH_DEFAULT) begin
            flag_error($sformatf("batch limit after reset is %0d", rd[7:0]));
        end
    endtask

    task automatic test_directed_sequence();
        // departure on an empty resource, direction field ignored
        send_beat(REQ_DEPART, TRAVEL_UP);
        // empty resource turns up, first arrival enters
        send_beat(REQ_ARRIVE, TRAVEL_UP);
        // down side starts waiting
        send_beat(REQ_ARRIVE, TRAVEL_DN);
        // up batch fills to the limit, then the last one waits
        repeat (5) send_beat(REQ_ARRIVE, TRAVEL_UP);
        // empty out; both sides wait, so the direction alternates to down
        repeat (5) send_beat(REQ_DEPART, TRAVEL_DN);
        // the down user leaves and the waiting up user is let on
        send_beat(REQ_DEPART, TRAVEL_UP);

        // smallest batch: the one extra admission past a used-up batch
        set_batch_limit(8'd1);
        send_beat(REQ_ARRIVE, TRAVEL_DN);
        send_beat(REQ_ARRIVE, TRAVEL_UP);
        send_beat(REQ_ARRIVE, TRAVEL_UP);
        repeat (2) send_beat(REQ_DEPART, TRAVEL_DN);

        // zero limit acts as the default
        set_batch_limit(8'd0);
        repeat (2) send_beat(REQ_ARRIVE, TRAVEL_DN);
        repeat (3) send_beat(REQ_ARRIVE, TRAVEL_UP);
        drain_resource();
    endtask

    // Fill one waiting counter past its limit, then flood the resource so
    // occupancy hits its ceiling and the batch count saturates
    task automatic test_counter_limits();
        logic d;
        set_batch_limit(BATCH_DEFAULT);
        for (int k = 0; k < 2; k++) begin
            d = k[0];
            // hold the resource with one user of the other direction
            send_beat(REQ_ARRIVE, ~d);
            repeat (USER_LIMIT + 1) send_beat(REQ_ARRIVE, d);
            // all waiters rush on up to the occupancy ceiling
            send_beat(REQ_DEPART, d);
            repeat (2) send_beat(REQ_ARRIVE, d);
            send_beat(REQ_DEPART, ~d);
            drain_resource();
        end
    endtask

    task automatic test_random_traffic();
        logic [7:0]  phase_limits[6];
        int unsigned dep_pct;
        phase_limits = '{8'd255, 8'd1, 8'd2, 8'd0, 8'd5, 8'd5};
        phase_limits[4] = 8'($urandom_range(3, 254));
        foreach (phase_limits[p]) begin
            set_batch_limit(phase_limits[p]);
            dep_pct = $urandom_range(35, 60);
            repeat (150) begin
                send_beat(($urandom_range(99) < dep_pct) ? REQ_DEPART : REQ_ARRIVE,
                          1'($urandom_range(1)));
            end
        end
    endtask

    task automatic test_full_rate();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        set_batch_limit(8'd3);
        repeat (250) begin
            send_beat(($urandom_range(99) < 48) ? REQ_DEPART : REQ_ARRIVE,
                      1'($urandom_range(1)));
        end
        wait_idle();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_directed_sequence();
        test_counter_limits();
        test_random_traffic();
        test_full_rate();

        wait_idle();
        if (grant_queue.size() != 0) begin
            flag_error($sformatf("%0d grants never arrived", grant_queue.size()));
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
